### sv/frcull_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frcull_pkg: shared types and constants of the frustum sphere culler
// Plane layout, function codes, normalizer states and small helpers.
// ----------------------------------------------------------------------------
package frcull_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NPLANES       = 6;
  localparam int NCOMP         = 4;
  localparam int NENT          = NPLANES * NCOMP;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SPHERE = 1'b1;

  localparam logic [1:0] COL_W = 2'd3;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQ,
    NS_SQRT,
    NS_DLOAD,
    NS_DIV,
    NS_WRITE
  } nstate_t;

  typedef struct packed {
    logic       en;
    logic [1:0] column;
  } load_req_t;

  // Axis that each plane takes from a matrix column: x, x, y, y, z, z.
  function automatic logic [1:0] plane_axis(input logic [2:0] p);
    logic [1:0] a;
    case (p)
      3'd0, 3'd1: a = 2'd0;
      3'd2, 3'd3: a = 2'd1;
      default:    a = 2'd2;
    endcase
    return a;
  endfunction

  // Planes right, top and front subtract the axis entry from w.
  function automatic logic plane_neg(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  function automatic word_t sat33(input logic signed [32:0] v);
    word_t r;
    if (v[32] != v[31]) begin
      r = v[32] ? word_t'(32'h8000_0000) : word_t'(32'h7fff_ffff);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/frcull_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frcull_norm: plane store and normalizing sequencer
// Holds the raw and normalized planes. A load of the w column starts a
// sequence that sums squares, takes an integer square root and divides each
// component by the length, one bit per cycle; zero-length planes are copied.
// ----------------------------------------------------------------------------
module frcull_norm import frcull_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire load_req_t load,
  input  wire word_t     col_x,
  input  wire word_t     col_y,
  input  wire word_t     col_z,
  input  wire word_t     col_w,
  output logic           busy,
  output word_t          norm_planes [NENT]
);

  localparam int NW  = 33 + FRAC_BITS;
  localparam int QCW = $clog2(NW + 1);

  word_t   raw_r  [NENT];
  word_t   norm_r [NENT];
  nstate_t state_r, state_nxt;
  logic [2:0]     plane_r, plane_nxt;
  logic [1:0]     comp_r, comp_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [63:0]    sv_r, sv_nxt;
  logic [63:0]    sq_r, sq_nxt;
  logic [63:0]    bit_r, bit_nxt;
  logic [32:0]    rem_r, rem_nxt;
  logic [NW-1:0]  num_r, num_nxt;
  logic [NW-1:0]  quo_r, quo_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  logic [4:0]  idx;
  word_t       rd;
  logic [31:0] rmag;
  logic [31:0] len;
  logic [63:0] prod;
  logic [63:0] trial;
  logic [33:0] rem_sh;
  logic        ge;
  logic        wr_en;
  word_t       wr_data;
  word_t       axv [3];

  assign idx    = {plane_r, comp_r};
  assign rd     = raw_r[idx];
  assign rmag   = rd[31] ? (~rd + 32'd1) : rd;
  assign len    = sq_r[31:0];
  assign prod   = 64'(rmag) * 64'(rmag);
  assign trial  = sq_r + bit_r;
  assign rem_sh = {rem_r, num_r[NW-1]};
  assign ge     = rem_sh >= {2'b00, len};
  assign busy   = (state_r != NS_IDLE);
  assign axv[0] = col_x;
  assign axv[1] = col_y;
  assign axv[2] = col_z;

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    comp_nxt  = comp_r;
    acc_nxt   = acc_r;
    sv_nxt    = sv_r;
    sq_nxt    = sq_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_data   = rd;
    unique case (state_r)
      NS_IDLE: begin
        if (load.en && load.column == COL_W) begin
          state_nxt = NS_SQ;
          plane_nxt = 3'd0;
          comp_nxt  = 2'd0;
          acc_nxt   = 64'd0;
        end
      end
      NS_SQ: begin
        acc_nxt = acc_r + prod;
        if (comp_r == 2'd2) begin
          sv_nxt    = acc_r + prod;
          sq_nxt    = 64'd0;
          bit_nxt   = 64'd1 << 62;
          state_nxt = NS_SQRT;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
      NS_SQRT: begin
        if (sv_r >= trial) begin
          sv_nxt = sv_r - trial;
          sq_nxt = (sq_r >> 1) + bit_r;
        end else begin
          sq_nxt = sq_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 64'd1) begin
          comp_nxt  = 2'd0;
          state_nxt = NS_DLOAD;
        end
      end
      NS_DLOAD: begin
        num_nxt = NW'({rmag, {FRAC_BITS{1'b0}}}) + NW'(len >> 1);
        rem_nxt = 33'd0;
        quo_nxt = '0;
        cnt_nxt = QCW'(NW);
        if (len == 32'd0) begin
          wr_en   = 1'b1;
          wr_data = rd;
        end else begin
          state_nxt = NS_DIV;
        end
      end
      NS_DIV: begin
        rem_nxt = ge ? 33'(rem_sh - {2'b00, len}) : rem_sh[32:0];
        quo_nxt = {quo_r[NW-2:0], ge};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - QCW'(1);
        if (cnt_r == QCW'(1)) begin
          state_nxt = NS_WRITE;
        end
      end
      NS_WRITE: begin
        wr_en = 1'b1;
        if (rd[31]) begin
          wr_data = (quo_r > NW'(33'h0_8000_0000)) ? word_t'(32'h8000_0000)
                                                  : word_t'(~quo_r[31:0] + 32'd1);
        end else begin
          wr_data = (quo_r > NW'(32'h7fff_ffff)) ? word_t'(32'h7fff_ffff)
                                                : word_t'(quo_r[31:0]);
        end
      end
      default: state_nxt = NS_IDLE;
    endcase
    if (wr_en) begin
      if (comp_r == 2'd3) begin
        comp_nxt = 2'd0;
        if (plane_r == 3'(NPLANES - 1)) begin
          state_nxt = NS_IDLE;
        end else begin
          plane_nxt = plane_r + 3'd1;
          acc_nxt   = 64'd0;
          state_nxt = NS_SQ;
        end
      end else begin
        comp_nxt  = comp_r + 2'd1;
        state_nxt = NS_DLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= plane_nxt;
    comp_r  <= comp_nxt;
    acc_r   <= acc_nxt;
    sv_r    <= sv_nxt;
    sq_r    <= sq_nxt;
    bit_r   <= bit_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NENT; i++) begin
        raw_r[i]  <= '0;
        norm_r[i] <= '0;
      end
    end else begin
      if (load.en) begin
        for (int p = 0; p < NPLANES; p++) begin
          raw_r[{3'(p), load.column}] <= plane_neg(3'(p))
            ? sat33(33'(col_w) - 33'(axv[plane_axis(3'(p))]))
            : sat33(33'(col_w) + 33'(axv[plane_axis(3'(p))]));
        end
      end
      if (wr_en) begin
        norm_r[idx] <= wr_data;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NENT; i++) begin
      norm_planes[i] = norm_r[i];
    end
  end

endmodule
`default_nettype wire

### sv/frcull_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frcull_test: sphere test pipeline
// Four stages: products, pair sums, plane sums, visibility flag. Each stage
// holds its item while the next one is full and stalled.
// ----------------------------------------------------------------------------
module frcull_test import frcull_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        sph_en,
  input  wire word_t       center_x,
  input  wire word_t       center_y,
  input  wire word_t       center_z,
  input  wire logic [30:0] sphere_radius,
  input  wire word_t       norm_planes [NENT],
  input  wire logic        out_stall,
  output logic             ready,
  output logic             out_valid,
  output logic             out_visible
);

  logic signed [63:0] t_r [NPLANES][NCOMP];
  logic signed [64:0] a_r [NPLANES];
  logic signed [64:0] b_r [NPLANES];
  logic signed [65:0] s_r [NPLANES];
  logic v1_r, v2_r, v3_r, ov_r, vis_r;
  logic r1, r2, r3, r4;
  logic vis_nxt;

  assign r4    = !ov_r || !out_stall;
  assign r3    = !v3_r || r4;
  assign r2    = !v2_r || r3;
  assign r1    = !v1_r || r2;
  assign ready = r1;

  always_comb begin
    vis_nxt = 1'b1;
    for (int p = 0; p < NPLANES; p++) begin
      if (s_r[p] <= 66'sd0) begin
        vis_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (r1) v1_r <= sph_en;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NPLANES; p++) begin
      if (r1 && sph_en) begin
        t_r[p][0] <= norm_planes[p*NCOMP+0] * center_x;
        t_r[p][1] <= norm_planes[p*NCOMP+1] * center_y;
        t_r[p][2] <= norm_planes[p*NCOMP+2] * center_z;
        t_r[p][3] <= 64'(33'(norm_planes[p*NCOMP+3]) + $signed({2'b00, sphere_radius}))
                     <<< FRAC_BITS;
      end
      if (r2 && v1_r) begin
        a_r[p] <= 65'(t_r[p][0]) + 65'(t_r[p][1]);
        b_r[p] <= 65'(t_r[p][2]) + 65'(t_r[p][3]);
      end
      if (r3 && v2_r) begin
        s_r[p] <= 66'(a_r[p]) + 66'(b_r[p]);
      end
    end
    if (r4 && v3_r) begin
      vis_r <= vis_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_visible = vis_r;

endmodule
`default_nettype wire

### sv/frustum_sphere_culler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_sphere_culler: frustum plane extraction and sphere culling
// Sphere requests are taken one per cycle while in_stall is low, and their
// visible flag passes through the products, pair sums, plane sums and flag
// stages of frcull_test. Loads of matrix columns 0 to 2 give no result. A
// load of column 3 starts the plane normalizer, a sequencer with one square
// unit, a one-bit-per-cycle square root and a one-bit-per-cycle divider;
// input is stalled while it runs. Spheres accepted before the load are
// tested against the old planes.
// ----------------------------------------------------------------------------
module frustum_sphere_culler import frcull_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [1:0]  in_column,
  input  wire word_t       in_col_x,
  input  wire word_t       in_col_y,
  input  wire word_t       in_col_z,
  input  wire word_t       in_col_w,
  input  wire word_t       in_center_x,
  input  wire word_t       in_center_y,
  input  wire word_t       in_center_z,
  input  wire logic [30:0] in_sphere_radius,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_visible
);

  logic      busy;
  logic      ready;
  logic      accept;
  load_req_t load;
  word_t     norm_planes [NENT];

  assign in_stall    = busy || !ready;
  assign accept      = in_valid && !in_stall;
  assign load.en     = accept && (in_func == FUNC_LOAD);
  assign load.column = in_column;

  frcull_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .col_x       (in_col_x),
    .col_y       (in_col_y),
    .col_z       (in_col_z),
    .col_w       (in_col_w),
    .busy        (busy),
    .norm_planes (norm_planes)
  );

  frcull_test #(.FRAC_BITS(FRAC_BITS)) u_test (
    .clk           (clk),
    .rst_n         (rst_n),
    .sph_en        (accept && (in_func == FUNC_SPHERE)),
    .center_x      (in_center_x),
    .center_y      (in_center_y),
    .center_z      (in_center_z),
    .sphere_radius (in_sphere_radius),
    .norm_planes   (norm_planes),
    .out_stall     (out_stall),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_visible   (out_visible)
  );

endmodule
`default_nettype wire

### dv/tb_frustum_sphere_culler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frustum_sphere_culler: self-checking bench for the frustum sphere culler
// Drives matrix column loads and sphere requests with random gaps and output
// stalls, predicts every visible flag from its own plane model and compares.
// ----------------------------------------------------------------------------
module tb_frustum_sphere_culler;
  import frcull_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  class cull_scoreboard;
    longint raw_pl[NENT];
    longint nrm_pl[NENT];
    bit exp_vis[$];
    int errors;
    int checked;

    function new();
      foreach (raw_pl[i]) begin
        raw_pl[i] = 0;
        nrm_pl[i] = 0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void renormalize();
      longint unsigned s;
      longint unsigned len;
      longint unsigned m;
      longint unsigned q;
      longint c;
      for (int p = 0; p < NPLANES; p++) begin
        s = 0;
        for (int k = 0; k < 3; k++) begin
          c = raw_pl[p*4+k];
          m = (c < 0) ? -c : c;
          s += m * m;
        end
        len = root64(s);
        for (int k = 0; k < 4; k++) begin
          c = raw_pl[p*4+k];
          if (len == 0) begin
            nrm_pl[p*4+k] = c;
          end else begin
            m = (c < 0) ? -c : c;
            q = ((m << FB) + (len >> 1)) / len;
            if (c < 0) nrm_pl[p*4+k] = (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
            else nrm_pl[p*4+k] = (q > 64'h7fff_ffff) ? 64'sd2147483647 : longint'(q);
          end
        end
      end
    endfunction

    function void note_request(bit fn, bit [1:0] col, word_t x, word_t y, word_t z,
                               word_t w, word_t cx, word_t cy, word_t cz,
                               bit [30:0] rad);
      longint a[3];
      longint acc;
      bit vis;
      if (fn == FUNC_LOAD) begin
        a[0] = x;
        a[1] = y;
        a[2] = z;
        for (int p = 0; p < NPLANES; p++) begin
          raw_pl[p*4+col] = clip32(plane_neg(p) ? longint'(w) - a[plane_axis(p)]
                                                : longint'(w) + a[plane_axis(p)]);
        end
        if (col == COL_W) renormalize();
      end else begin
        vis = 1;
        for (int p = 0; p < NPLANES; p++) begin
          // Each product fits 63 bits and the sum stays well within 64.
          acc = nrm_pl[p*4] * cx + nrm_pl[p*4+1] * cy + nrm_pl[p*4+2] * cz
              + ((nrm_pl[p*4+3] + longint'(rad)) <<< FB);
          if (acc <= 0) vis = 0;
        end
        exp_vis.push_back(vis);
      end
    endfunction

    function void check_result(bit got);
      bit e;
      if (exp_vis.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual visible=%0b", $time, got);
        errors++;
        return;
      end
      e = exp_vis.pop_front();
      checked++;
      if (e !== got) begin
        $display("%0t: visible mismatch, expected %0b, actual %0b", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_func = 0;
  logic [1:0] in_column = 0;
  word_t in_col_x = 0, in_col_y = 0, in_col_z = 0, in_col_w = 0;
  word_t in_center_x = 0, in_center_y = 0, in_center_z = 0;
  logic [30:0] in_sphere_radius = 0;
  logic out_stall = 0;
  wire in_stall, out_valid, out_visible;

  cull_scoreboard sb;
  longint cycles = 0;
  int hold_cycles = 0;
  int loads_sent = 0;
  int spheres_sent = 0;
  bit stim_done = 0;

  always #5 clk = ~clk;

  frustum_sphere_culler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_column(in_column), .in_col_x(in_col_x), .in_col_y(in_col_y),
    .in_col_z(in_col_z), .in_col_w(in_col_w), .in_center_x(in_center_x),
    .in_center_y(in_center_y), .in_center_z(in_center_z),
    .in_sphere_radius(in_sphere_radius),
    .out_valid(out_valid), .out_stall(out_stall), .out_visible(out_visible)
  );

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7fff_ffff - $urandom_range(0, 3);
      3: return word_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  task automatic send(bit fn, bit [1:0] col, word_t x, word_t y, word_t z, word_t w,
                      word_t cx, word_t cy, word_t cz, bit [30:0] rad, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_func <= fn;
    in_column <= col;
    in_col_x <= x;
    in_col_y <= y;
    in_col_z <= z;
    in_col_w <= w;
    in_center_x <= cx;
    in_center_y <= cy;
    in_center_z <= cz;
    in_sphere_radius <= rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(fn, col, x, y, z, w, cx, cy, cz, rad);
    if (fn == FUNC_LOAD) loads_sent++;
    else spheres_sent++;
  endtask

  task automatic send_sphere(bit gaps);
    bit [30:0] rad;
    rad = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0003_0000));
    send(FUNC_SPHERE, 0, rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word(), rand_word(), rand_word(), rad, gaps);
  endtask

  task automatic send_matrix(bit gaps);
    for (int k = 0; k < 4; k++)
      send(FUNC_LOAD, k[1:0], rand_word(), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word(), rand_word(), 31'($urandom), gaps);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_visible);
  end

  // Output stall: random per result, plus one long hold-off.
  initial begin
    int w;
    @(posedge rst_n);
    while (!stim_done) begin
      if (hold_cycles > 0) begin
        out_stall <= 1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w != 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
    out_stall <= 0;
  end

  initial begin
    int sent;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Spheres against reset planes: only a zero radius is culled.
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 5, 5, 5, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, -5, 7, 1, 31'h7fff_ffff, 0);
    // Identity matrix.
    send(FUNC_LOAD, 0, 32'sh1_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    send(FUNC_LOAD, 1, 0, 32'sh1_0000, 0, 0, 0, 0, 0, 0, 0);
    send(FUNC_LOAD, 2, 0, 0, 32'sh1_0000, 0, 0, 0, 0, 0, 0);
    send(FUNC_LOAD, 3, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 32'sh2_0000, 0, 0, 31'h1_0000, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 32'sh2_0000, 0, 0, 31'h0_ffff, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
         31'h7fff_ffff, 0);
    // Saturating entries, then an all-zero matrix with zero-length planes.
    send(FUNC_LOAD, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
         0, 0, 0, 0, 0);
    send(FUNC_LOAD, 1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
         0, 0, 0, 0, 0);
    send(FUNC_LOAD, 3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         0, 0, 0, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 32'sh0001_0000, -1, 3, 31'h10, 0);
    for (int k = 0; k < 4; k++)
      send(FUNC_LOAD, k[1:0], 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 1, 2, 3, 0, 0);
    send(FUNC_SPHERE, 0, 0, 0, 0, 0, 1, 2, 3, 1, 0);
    // Long receiver hold-off while spheres keep arriving back to back.
    hold_cycles = 200;
    for (int i = 0; i < 40; i++) send_sphere(0);
    sent = 0;
    while (sent < 1500) begin
      if ($urandom_range(0, 29) == 0) begin
        send_matrix(1);
        sent += 4;
      end else if ($urandom_range(0, 40) == 0) begin
        send(FUNC_LOAD, 2'($urandom_range(0, 2)), rand_word(), rand_word(), rand_word(),
             rand_word(), 0, 0, 0, 0, 1);
        sent++;
      end else begin
        send_sphere(sent % 300 < 150);
        sent++;
      end
    end
    in_valid <= 0;
    while (sb.exp_vis.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    stim_done = 1;
    $display("Sent %0d column loads and %0d spheres; %0d visible flags checked.",
             loads_sent, spheres_sent, sb.checked);
    if (sb.errors == 0 && sb.exp_vis.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### frustum_sphere_culler.f
sv/frcull_pkg.sv
sv/frcull_norm.sv
sv/frcull_test.sv
sv/frustum_sphere_culler.sv
dv/tb_frustum_sphere_culler.sv
